[rtl/core/cma_pkg.sv]
// Shared types and constants for the centered moving average anomaly block.
// Holds the payload structs, register codes, controller states and the
// command and status bundles. Depends on nothing.
`default_nettype none

package cma_pkg;

    // Field widths fixed by the payload format.
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 8;
    localparam int AVG_W      = SAMPLE_W + FRAC_W;
    localparam int CFG_W      = 16;

    // Default window length for the top level parameter.
    localparam int DEF_WINDOW = 5;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_LSB = 2;

    // Register reset values.
    localparam logic [CFG_W-1:0] THRESH_RESET = 16'd100;
    localparam logic [CFG_W-1:0] HLIMIT_RESET = 16'd140;

    // Register indexes.
    typedef enum logic [0:0] {
        REG_THRESH = 1'b0,
        REG_HLIMIT = 1'b1
    } reg_idx_t;

    // One input transaction.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       final_sample;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic signed [AVG_W-1:0]    average_q8;
        logic signed [SAMPLE_W-1:0] raw_echo;
        logic                       anomaly;
        logic                       final_result;
    } out_item_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLAN,
        ST_SETUP,
        ST_FETCH,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_EMIT,
        ST_UPDATE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic setup;
        logic fetch;
        logic sum_step;
        logic check;
        logic load_out;
        logic next_centre;
        logic update;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_emit;
        logic tap_last;
        logic div_busy;
        logic out_free;
        logic centre_last;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/cma_div.sv]
// Restoring divider for the window average, one quotient bit per cycle.
// Unsigned dividend and divisor; reports a nonzero remainder for rounding.
// Depends on nothing outside this file.
`default_nettype none

module cma_div #(
    parameter int DIVW = 29,
    parameter int DVSW = 3
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [DIVW-1:0] dividend,
    input  logic [DVSW-1:0] divisor,
    output logic            busy,
    output logic [DIVW-1:0] quotient,
    output logic            rem_nz
);

    localparam int STEPW = (DIVW > 1) ? $clog2(DIVW) : 1;
    localparam logic [STEPW-1:0] LAST_STEP = STEPW'(DIVW - 1);

    logic [DIVW-1:0]  quo_reg;
    logic [DVSW-1:0]  rem_reg;
    logic [DVSW-1:0]  dvs_reg;
    logic [STEPW-1:0] step_reg;
    logic             busy_reg;

    logic [DVSW:0]    trial;
    logic [DVSW:0]    diff;
    logic             fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {rem_reg, quo_reg[DIVW-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // Busy flag and step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= LAST_STEP;
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg - STEPW'(1);
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVW-2:0], fits};
            rem_reg <= fits ? diff[DVSW-1:0] : trial[DVSW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);

endmodule

`default_nettype wire

[rtl/core/cma_ctrl.sv]
// Controller state machine for the centered moving average block.
// Sequences accept, per-result window summing, division and history update.
// Depends on cma_pkg.
`default_nettype none

module cma_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cma_pkg::dp_status_t status,
    output cma_pkg::dp_cmd_t    cmd
);

    import cma_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                state_next = status.has_emit ? ST_SETUP : ST_UPDATE;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (status.tap_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    if (status.centre_last) begin
                        state_next = ST_UPDATE;
                    end else begin
                        cmd.next_centre = 1'b1;
                        state_next      = ST_SETUP;
                    end
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/cma_dpath.sv]
// Datapath for the centered moving average block: sample window, tap
// accumulators, anomaly tests, the divider and the result register.
// Depends on cma_pkg and cma_div.
`default_nettype none

module cma_dpath #(
    parameter int WINDOW = cma_pkg::DEF_WINDOW
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  cma_pkg::dp_cmd_t                        cmd,
    output cma_pkg::dp_status_t                     status,
    input  cma_pkg::in_item_t                       s_data,
    input  logic [cma_pkg::CFG_W-1:0]               thresh,
    input  logic signed [cma_pkg::CFG_W-1:0]        hlimit,
    input  logic                                    m_ready,
    output logic                                    m_valid,
    output cma_pkg::out_item_t                      m_data
);

    import cma_pkg::*;

    localparam int HALF  = WINDOW / 2;
    localparam int FW    = $clog2(WINDOW);
    localparam int IW    = FW + 1;
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int BASEW = (SAMPLE_W > CFG_W) ? SAMPLE_W : CFG_W;
    localparam int ACCW  = BASEW + CW + 2;
    localparam int DIVW  = ACCW + FRAC_W;

    localparam logic [IW-1:0] HALF_I = IW'(HALF);
    localparam logic [FW-1:0] LAST_F = FW'(WINDOW - 1);

    // Window storage: history entries followed by the newest sample.
    logic signed [SAMPLE_W-1:0] win_reg [WINDOW];
    logic [FW-1:0]              fill_reg;
    logic [FW-1:0]              centre_reg;
    logic [FW-1:0]              last_reg;
    logic [FW-1:0]              tap_reg;
    logic [FW-1:0]              lo_reg;
    logic [FW-1:0]              hi_reg;
    logic                       final_reg;
    logic                       has_emit_reg;

    // Per-result accumulators.
    logic signed [SAMPLE_W-1:0] raw_reg;
    logic signed [ACCW-1:0]     sum_reg;
    logic signed [ACCW-1:0]     rawacc_reg;
    logic signed [ACCW-1:0]     thracc_reg;
    logic signed [ACCW-1:0]     hlacc_reg;
    logic signed [ACCW-1:0]     dev_reg;
    logic [CW-1:0]              count_reg;
    logic                       neg_reg;

    // Result register.
    logic                       out_valid_reg;
    out_item_t                  out_reg;

    // Plan and window bound logic.
    logic [IW-1:0]              fill_i;
    logic [IW-1:0]              lag_i;
    logic                       ge_half;
    logic [IW-1:0]              cen_i;
    logic [IW-1:0]              lo_i;
    logic [IW-1:0]              hi_sum;
    logic [IW-1:0]              hi_i;

    // Division and test logic.
    logic [ACCW-1:0]            sum_mag;
    logic [DIVW-1:0]            dividend;
    logic                       div_busy;
    logic [DIVW-1:0]            quotient;
    logic                       rem_nz;
    logic [DIVW-1:0]            q_adj;
    logic [DIVW-1:0]            avg_full;
    logic signed [ACCW-1:0]     abs_dev;
    logic                       anom;

    // Which centres a new sample settles, and the clipped window of one centre.
    always_comb begin
        fill_i  = IW'(fill_reg);
        ge_half = (fill_i >= HALF_I);
        lag_i   = fill_i - HALF_I;
        cen_i   = IW'(centre_reg);
        lo_i    = (cen_i >= HALF_I) ? (cen_i - HALF_I) : '0;
        hi_sum  = cen_i + HALF_I;
        hi_i    = (hi_sum > fill_i) ? fill_i : hi_sum;
    end

    // Magnitude of the window sum, scaled to Q8, feeds the divider.
    always_comb begin
        sum_mag  = sum_reg[ACCW-1] ? ACCW'(-sum_reg) : ACCW'(sum_reg);
        dividend = {sum_mag, {FRAC_W{1'b0}}};
    end

    // Floor rounding of the signed quotient and the two anomaly tests.
    always_comb begin
        q_adj    = quotient + DIVW'(neg_reg && rem_nz);
        avg_full = neg_reg ? (-q_adj) : q_adj;
        abs_dev  = dev_reg[ACCW-1] ? (-dev_reg) : dev_reg;
        anom     = (abs_dev > thracc_reg) || (sum_reg > hlacc_reg);
    end

    // Window write on accept, shift on update once the history is full.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            win_reg[fill_reg] <= s_data.sample;
        end else if (cmd.update && !final_reg && (fill_reg == LAST_F)) begin
            for (int k = 0; k < WINDOW - 1; k++) begin
                win_reg[k] <= win_reg[k + 1];
            end
        end
    end

    // History fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.update) begin
            if (final_reg) begin
                fill_reg <= '0;
            end else if (fill_reg != LAST_F) begin
                fill_reg <= fill_reg + FW'(1);
            end
        end
    end

    // Range of centres to report for the accepted sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            final_reg    <= 1'b0;
            has_emit_reg <= 1'b0;
        end else if (cmd.accept) begin
            final_reg    <= s_data.final_sample;
            has_emit_reg <= s_data.final_sample || ge_half;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (s_data.final_sample) begin
                centre_reg <= ge_half ? lag_i[FW-1:0] : '0;
                last_reg   <= fill_reg;
            end else begin
                centre_reg <= lag_i[FW-1:0];
                last_reg   <= lag_i[FW-1:0];
            end
        end else if (cmd.next_centre) begin
            centre_reg <= centre_reg + FW'(1);
        end
    end

    // Tap walk: point at the centre first to read the raw sample, then sweep.
    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            lo_reg  <= lo_i[FW-1:0];
            hi_reg  <= hi_i[FW-1:0];
            tap_reg <= centre_reg;
        end else if (cmd.fetch) begin
            raw_reg <= win_reg[tap_reg];
            tap_reg <= lo_reg;
        end else if (cmd.sum_step) begin
            tap_reg <= tap_reg + FW'(1);
        end
    end

    // Accumulate the sum and the count-scaled raw value and limits.
    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            sum_reg    <= '0;
            rawacc_reg <= '0;
            thracc_reg <= '0;
            hlacc_reg  <= '0;
            count_reg  <= '0;
        end else if (cmd.sum_step) begin
            sum_reg    <= sum_reg + ACCW'(win_reg[tap_reg]);
            rawacc_reg <= rawacc_reg + ACCW'(raw_reg);
            thracc_reg <= thracc_reg + $signed(ACCW'(thresh));
            hlacc_reg  <= hlacc_reg + ACCW'(hlimit);
            count_reg  <= count_reg + CW'(1);
        end
    end

    // Deviation from the centre sample and the sign of the sum.
    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            dev_reg <= sum_reg - rawacc_reg;
            neg_reg <= sum_reg[ACCW-1];
        end
    end

    cma_div #(
        .DIVW (DIVW),
        .DVSW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.check),
        .dividend (dividend),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (quotient),
        .rem_nz   (rem_nz)
    );

    // Result register; it holds until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.average_q8   <= avg_full[AVG_W-1:0];
            out_reg.raw_echo     <= raw_reg;
            out_reg.anomaly      <= anom;
            out_reg.final_result <= final_reg && (centre_reg == last_reg);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Status back to the controller.
    always_comb begin
        status.has_emit    = has_emit_reg;
        status.tap_last    = (tap_reg == hi_reg);
        status.div_busy    = div_busy;
        status.out_free    = !out_valid_reg || m_ready;
        status.centre_last = (centre_reg == last_reg);
    end

endmodule

`default_nettype wire

[rtl/core/centered_moving_average_anomaly.sv]
// Top level of the centered moving average anomaly block.
// Holds the configuration registers and joins controller and datapath.
// Depends on cma_pkg, cma_ctrl and cma_dpath.
//
//   Channel   Direction  Handshake        Payload
//   s_        in         s_valid/s_ready  in_item_t: sample, final_sample
//   m_        out        m_valid/m_ready  out_item_t: average_q8, raw_echo, anomaly,
//                                         final_result
//   APB       in         psel/penable     registers at 0x0 (threshold), 0x4 (level)
//
// Per result the block walks the window taps, then runs the bit-serial divider
// over its quotient bits (29 with the default window), which dominates the
// work; a final sample gives up to three results with the default window.
// Reset is synchronous, active low, and empties the history.
// A waiting result is held in the output register; the block accepts the
// next sample meanwhile and stalls only when a second result is ready.
`default_nettype none

module centered_moving_average_anomaly #(
    parameter int WINDOW = cma_pkg::DEF_WINDOW
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  cma_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output cma_pkg::out_item_t                 m_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cma_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cma_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cma_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    import cma_pkg::*;

    logic [CFG_W-1:0]        thresh_reg;
    logic signed [CFG_W-1:0] hlimit_reg;
    reg_idx_t                reg_idx;
    dp_cmd_t                 cmd;
    dp_status_t              status;

    assign reg_idx = reg_idx_t'(paddr[REG_IDX_LSB]);
    assign pready  = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
            hlimit_reg <= HLIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_THRESH: begin
                    thresh_reg <= pwdata[CFG_W-1:0];
                end
                REG_HLIMIT: begin
                    hlimit_reg <= pwdata[CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register read-back: threshold zero-extended, level sign-extended.
    always_comb begin
        case (reg_idx)
            REG_THRESH: begin
                prdata = {{(APB_DATA_W - CFG_W){1'b0}}, thresh_reg};
            end
            REG_HLIMIT: begin
                prdata = {{(APB_DATA_W - CFG_W){hlimit_reg[CFG_W-1]}}, hlimit_reg};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    cma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cma_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .thresh  (thresh_reg),
        .hlimit  (hlimit_reg),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

[rtl/core/cma_checker.sv]
// Port-level checks for the centered moving average block, bound to the top.
// Watches the sample and result handshakes over time.
// Depends on cma_pkg and centered_moving_average_anomaly.
`default_nettype none

module cma_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input cma_pkg::out_item_t m_data
);

    import cma_pkg::*;

    // A stalled result keeps its valid and its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Reset leaves the block empty and ready for a sample.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // A sample is worked on before the next one is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sample taken on consecutive cycles");

    // No result can appear in the cycle right after a sample transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

endmodule

bind centered_moving_average_anomaly cma_checker u_cma_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
